[hdl/ffp_pkg.sv]
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types, constants and the sine table generator of the Frenet-frame
// projection block.
// ----------------------------------------------------------------------------
package ffp_pkg;

	// Default sizes of the lane table and of the sine table.
	localparam int LANE_DEPTH_DEF = 1024;
	localparam int SINE_BITS_DEF  = 12;

	// Fixed field widths.
	localparam int CNT_W   = 11;
	localparam int IDX_W   = 10;
	localparam int POS_W   = 32;
	localparam int ANG_W   = 16;
	localparam int ARC_W   = 32;
	localparam int SPD_W   = 16;
	localparam int ACC_W   = 16;
	localparam int RES_W   = 17;

	// Half pi in Q30 for the table generator.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Item command codes.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// One lane point as stored in the lane memory.
	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [ANG_W-1:0]        heading;
		logic [ARC_W-1:0]        arc;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// One query item waiting for the back end.
	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [ANG_W-1:0]        heading;
		logic [SPD_W-1:0]        speed;
		logic signed [ACC_W-1:0] accel_x;
		logic signed [ACC_W-1:0] accel_y;
	} query_t;

	// Status of the back end as seen by the front end.
	typedef struct packed {
		logic busy;
		logic take;
	} back_stat_t;

	// First-quadrant sine in Q1.15 by an integer Taylor series in Q30.
	function automatic int quarter_sine(int k, int bits);
		longint unsigned x;
		longint unsigned term;
		longint          sum;
		begin
			x = (HALF_PI_Q30 * longint'(k)) >> (bits - 2);
			term = x;
			sum = longint'(x);
			term = (((term * x) >> 30) * x) >> 30;
			term = term / 6;
			sum = sum - longint'(term);
			term = (((term * x) >> 30) * x) >> 30;
			term = term / 20;
			sum = sum + longint'(term);
			term = (((term * x) >> 30) * x) >> 30;
			term = term / 42;
			sum = sum - longint'(term);
			term = (((term * x) >> 30) * x) >> 30;
			term = term / 72;
			sum = sum + longint'(term);
			term = (((term * x) >> 30) * x) >> 30;
			term = term / 110;
			sum = sum - longint'(term);
			term = (((term * x) >> 30) * x) >> 30;
			term = term / 156;
			sum = sum + longint'(term);
			term = (((term * x) >> 30) * x) >> 30;
			term = term / 210;
			sum = sum - longint'(term);
			if (sum < 0) begin
				sum = 0;
			end
			sum = (sum + 16384) >>> 15;
			if (sum > 32767) begin
				sum = 32767;
			end
			return int'(sum);
		end
	endfunction

	// Full-wave table entry built from quarter-wave symmetry.
	function automatic logic signed [15:0] sine_at(int i, int bits);
		int q;
		int r;
		int qn;
		int v;
		begin
			qn = 1 << (bits - 2);
			q = i >> (bits - 2);
			r = i & (qn - 1);
			if (q == 0) begin
				v = quarter_sine(r, bits);
			end else if (q == 1) begin
				v = quarter_sine(qn - r, bits);
			end else if (q == 2) begin
				v = -quarter_sine(r, bits);
			end else begin
				v = -quarter_sine(qn - r, bits);
			end
			return 16'(v);
		end
	endfunction

endpackage

[hdl/ffp_ram.sv]
// ----------------------------------------------------------------------------
// ffp_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/ffp_sine_rom.sv]
// ----------------------------------------------------------------------------
// ffp_sine_rom
// Q1.15 sine table with a registered read, contents built at elaboration.
// ----------------------------------------------------------------------------
module ffp_sine_rom #(
	parameter int SINE_TABLE_BITS = 12
) (
	input  logic                       clk,
	input  logic [SINE_TABLE_BITS-1:0] addr,
	output logic signed [15:0]         rdata
);

	import ffp_pkg::*;

	localparam int N = 1 << SINE_TABLE_BITS;

	logic signed [15:0] rom_c [N];

	// Constant contents.
	for (genvar g = 0; g < N; g++) begin : g_rom
		assign rom_c[g] = sine_at(g, SINE_TABLE_BITS);
	end

	// Registered read.
	always_ff @(posedge clk) begin
		rdata <= rom_c[addr];
	end

endmodule

[hdl/ffp_front.sv]
// ----------------------------------------------------------------------------
// ffp_front
// Accepts items, writes lane points into the lane memory and queues queries
// for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module ffp_front #(
	parameter int LANE_DEPTH = ffp_pkg::LANE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            cmd,
	input  logic [ffp_pkg::IDX_W-1:0]       point_index,
	input  logic signed [ffp_pkg::POS_W-1:0] pos_x,
	input  logic signed [ffp_pkg::POS_W-1:0] pos_y,
	input  logic [ffp_pkg::ANG_W-1:0]       heading,
	input  logic [ffp_pkg::ARC_W-1:0]       point_arc,
	input  logic [ffp_pkg::SPD_W-1:0]       speed,
	input  logic signed [ffp_pkg::ACC_W-1:0] accel_x,
	input  logic signed [ffp_pkg::ACC_W-1:0] accel_y,
	output logic                            wr_en,
	output logic [$clog2(LANE_DEPTH)-1:0]   wr_addr,
	output ffp_pkg::entry_t                 wr_data,
	output logic                            q_valid,
	output ffp_pkg::query_t                 q_data,
	input  ffp_pkg::back_stat_t             back_stat
);

	import ffp_pkg::*;

	localparam int AW = $clog2(LANE_DEPTH);

	query_t     fifo_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	logic       in_take;
	logic       idx_ok;

	// A load waits until every earlier query has left the back end.
	assign in_ready = (cmd == CMD_QUERY) ? (count_q != 2'd2)
	                                     : ((count_q == 2'd0) && !back_stat.busy);
	assign in_take  = in_valid && in_ready;
	assign push     = in_take && (cmd == CMD_QUERY);
	assign pop      = back_stat.take;

	// Lane point write; an index beyond the table is dropped.
	assign idx_ok  = 32'(point_index) < 32'(LANE_DEPTH);
	assign wr_en   = in_take && (cmd == CMD_LOAD) && idx_ok;
	assign wr_addr = AW'(point_index);
	assign wr_data = '{x: pos_x, y: pos_y, heading: heading, arc: point_arc};

	assign q_valid = (count_q != 2'd0);
	assign q_data  = fifo_q[rptr_q];

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= '{pos_x: pos_x, pos_y: pos_y, heading: heading,
			                    speed: speed, accel_x: accel_x, accel_y: accel_y};
		end
	end

endmodule

[hdl/ffp_back.sv]
// ----------------------------------------------------------------------------
// ffp_back
// Scans the lane memory for the nearest point, one point per cycle, then
// projects position, speed and acceleration onto that point's frame.
// ----------------------------------------------------------------------------
module ffp_back #(
	parameter int LANE_DEPTH      = ffp_pkg::LANE_DEPTH_DEF,
	parameter int SINE_TABLE_BITS = ffp_pkg::SINE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ffp_pkg::CNT_W-1:0]         lane_points,
	input  logic                              q_valid,
	input  ffp_pkg::query_t                   q_data,
	output ffp_pkg::back_stat_t               back_stat,
	output logic [$clog2(LANE_DEPTH)-1:0]     rd_addr,
	input  ffp_pkg::entry_t                   rd_data,
	output logic [SINE_TABLE_BITS-1:0]        rom_addr,
	input  logic signed [15:0]                rom_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ffp_pkg::IDX_W-1:0]         nearest_index,
	output logic [ffp_pkg::ARC_W-1:0]         along_track,
	output logic signed [ffp_pkg::POS_W-1:0]  lateral_offset,
	output logic signed [ffp_pkg::RES_W-1:0]  tangent_speed,
	output logic signed [ffp_pkg::RES_W-1:0]  normal_speed,
	output logic signed [ffp_pkg::RES_W-1:0]  tangent_accel,
	output logic signed [ffp_pkg::RES_W-1:0]  normal_accel
);

	import ffp_pkg::*;

	localparam int AW = $clog2(LANE_DEPTH);
	localparam int SB = SINE_TABLE_BITS;
	localparam logic [SB-1:0] QTR = SB'(1 << (SB - 2));

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

	state_t   state_q;
	query_t   qry_q;
	logic [AW-1:0] last_idx_q;
	logic [AW-1:0] iss_idx_q;
	logic     issuing_q;
	logic [2:0] ph_q;

	// Scan pipeline.
	logic          v_s1, v_s2, v_s3;
	logic          last_s1, last_s2, last_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	entry_t        ent_s2, ent_s3;
	logic [32:0]   ex_s2, ey_s2;
	logic [64:0]   sx_s3, sy_s3;

	// Best point so far.
	logic [AW-1:0] best_idx_q;
	logic [65:0]   best_dist_q;
	entry_t        best_q;

	// Projection operands and products.
	logic signed [32:0] dx_q, dy_q;
	logic signed [15:0] s_h_q, c_h_q, s_d_q, c_d_q;
	logic signed [48:0] p_dyc_q, p_dxs_q;
	logic signed [31:0] p_axc_q, p_ays_q, p_ayc_q, p_axs_q;
	logic signed [32:0] p_sc_q, p_ss_q;

	logic [31:0]        n_eff;
	logic signed [32:0] dxn, dyn;
	logic [32:0]        ex_n, ey_n;
	logic [65:0]        dist_n;
	logic [ANG_W-1:0]   diff_n;
	logic [SB-1:0]      h_idx, d_idx;
	logic signed [49:0] lat_sum;
	logic signed [34:0] lat_fl;
	logic signed [32:0] ta_sum, na_sum;
	logic               out_free;
	logic               fin_go;
	logic               take;

	// Points searched: zero counts as one, larger than the table saturates.
	always_comb begin
		if (lane_points == '0) begin
			n_eff = 32'd1;
		end else if (32'(lane_points) > 32'(LANE_DEPTH)) begin
			n_eff = 32'(LANE_DEPTH);
		end else begin
			n_eff = 32'(lane_points);
		end
	end

	assign take      = (state_q == S_IDLE) && q_valid;
	assign back_stat = '{busy: (state_q != S_IDLE), take: take};
	assign rd_addr   = iss_idx_q;

	// Distance terms of the point just read.
	assign dxn  = {qry_q.pos_x[31], qry_q.pos_x} - {rd_data.x[31], rd_data.x};
	assign dyn  = {qry_q.pos_y[31], qry_q.pos_y} - {rd_data.y[31], rd_data.y};
	assign ex_n = dxn[32] ? 33'(-dxn) : 33'(dxn);
	assign ey_n = dyn[32] ? 33'(-dyn) : 33'(dyn);
	assign dist_n = {1'b0, sx_s3} + {1'b0, sy_s3};

	// Sine table addressing for the point heading and the heading difference.
	assign diff_n = qry_q.heading - best_q.heading;
	assign h_idx  = best_q.heading[ANG_W-1 -: SB];
	assign d_idx  = diff_n[ANG_W-1 -: SB];
	always_comb begin
		case (ph_q)
			3'd0:    rom_addr = h_idx;
			3'd1:    rom_addr = h_idx + QTR;
			3'd2:    rom_addr = d_idx;
			default: rom_addr = d_idx + QTR;
		endcase
	end

	// Sums of products, floored by an arithmetic shift.
	assign lat_sum = 50'(p_dyc_q) - 50'(p_dxs_q);
	assign lat_fl  = lat_sum[49:15];
	assign ta_sum  = 33'(p_axc_q) + 33'(p_ays_q);
	assign na_sum  = 33'(p_ayc_q) - 33'(p_axs_q);
	assign out_free = !out_valid || out_ready;
	assign fin_go   = (state_q == S_FIN) && (ph_q >= 3'd6) && out_free;

	// Control, scan pipeline and projection.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			issuing_q <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			ph_q      <= 3'd0;
			out_valid <= 1'b0;
		end else begin
			// A new result replaces a taken one; otherwise a taken result clears.
			if (fin_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end

			// Pipeline advance.
			v_s1    <= (state_q == S_SCAN) && issuing_q;
			idx_s1  <= iss_idx_q;
			last_s1 <= (iss_idx_q == last_idx_q);
			v_s2    <= v_s1;
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
			ent_s2  <= rd_data;
			ex_s2   <= ex_n;
			ey_s2   <= ey_n;
			v_s3    <= v_s2;
			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
			ent_s3  <= ent_s2;
			sx_s3   <= 65'(ex_s2 * ex_s2);
			sy_s3   <= 65'(ey_s2 * ey_s2);

			// Keep the first point with the least distance.
			if (v_s3 && ((idx_s3 == '0) || (dist_n < best_dist_q))) begin
				best_idx_q  <= idx_s3;
				best_dist_q <= dist_n;
				best_q      <= ent_s3;
			end

			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						qry_q      <= q_data;
						last_idx_q <= AW'(n_eff - 32'd1);
						iss_idx_q  <= '0;
						issuing_q  <= 1'b1;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issuing_q) begin
						if (iss_idx_q == last_idx_q) begin
							issuing_q <= 1'b0;
						end else begin
							iss_idx_q <= iss_idx_q + 1'b1;
						end
					end
					if (v_s3 && last_s3) begin
						ph_q    <= 3'd0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (ph_q != 3'd6) begin
						ph_q <= ph_q + 3'd1;
					end
					case (ph_q)
						3'd0: begin
							dx_q <= {qry_q.pos_x[31], qry_q.pos_x} - {best_q.x[31], best_q.x};
							dy_q <= {qry_q.pos_y[31], qry_q.pos_y} - {best_q.y[31], best_q.y};
						end
						3'd1: s_h_q <= rom_data;
						3'd2: c_h_q <= rom_data;
						3'd3: s_d_q <= rom_data;
						3'd4: c_d_q <= rom_data;
						3'd5: begin
							p_dyc_q <= dy_q * c_h_q;
							p_dxs_q <= dx_q * s_h_q;
							p_axc_q <= qry_q.accel_x * c_h_q;
							p_ays_q <= qry_q.accel_y * s_h_q;
							p_ayc_q <= qry_q.accel_y * c_h_q;
							p_axs_q <= qry_q.accel_x * s_h_q;
							p_sc_q  <= $signed({1'b0, qry_q.speed}) * c_d_q;
							p_ss_q  <= $signed({1'b0, qry_q.speed}) * s_d_q;
						end
						default: begin
							if (fin_go) begin
								nearest_index <= IDX_W'(best_idx_q);
								along_track   <= best_q.arc;
								if (lat_fl[34:31] != {4{lat_fl[31]}}) begin
									lateral_offset <= lat_fl[34] ? {1'b1, {31{1'b0}}}
									                            : {1'b0, {31{1'b1}}};
								end else begin
									lateral_offset <= lat_fl[31:0];
								end
								tangent_speed <= p_sc_q[31:15];
								normal_speed  <= p_ss_q[31:15];
								tangent_accel <= ta_sum[31:15];
								normal_accel  <= na_sum[31:15];
								state_q       <= S_IDLE;
							end
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The chosen point lies within the searched range.
	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (best_idx_q <= last_idx_q))
		else $error("nearest point outside searched range");

	// No scan data is in flight while waiting for a query.
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("scan pipeline busy while idle");

	// Once issue stops, the last point is still in the pipeline.
	a_scan_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !issuing_q) |-> (v_s1 || v_s2 || v_s3))
		else $error("scan ended without its last point");

	// A query is taken only by an idle back end, and taking it starts a scan.
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == S_SCAN) && (iss_idx_q == '0 || $past(last_idx_q) == '0))
		else $error("query start did not begin a scan");

endmodule

[hdl/frenet_frame_projection_top.sv]
// ----------------------------------------------------------------------------
// frenet_frame_projection_top
// Frenet-frame projection of a vehicle state onto a stored lane center line.
//
//   channel  direction  handshake                payload
//   in       input      in_valid / in_ready      cmd .. accel_y
//   out      output     out_valid / out_ready    nearest_index .. normal_accel
//   cfg      input      cfg_valid / cfg_ready    cfg_data (lane_points)
//
// A load item is taken once no query is pending; it waits while a query is
// queued or held by the back end. A query holds the back end through the
// nearest-point scan, which reads one lane memory entry per cycle, and the
// projection that follows. Two queries can be queued while a scan runs.
// Reset is asynchronous; lane_points resets to one, lane memory is not cleared.
// A stalled output holds its result and keeps the back end from finishing.
// ----------------------------------------------------------------------------
module frenet_frame_projection_top #(
	parameter int LANE_DEPTH      = ffp_pkg::LANE_DEPTH_DEF,
	parameter int SINE_TABLE_BITS = ffp_pkg::SINE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ffp_pkg::CNT_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [ffp_pkg::IDX_W-1:0]         point_index,
	input  logic signed [ffp_pkg::POS_W-1:0]  pos_x,
	input  logic signed [ffp_pkg::POS_W-1:0]  pos_y,
	input  logic [ffp_pkg::ANG_W-1:0]         heading,
	input  logic [ffp_pkg::ARC_W-1:0]         point_arc,
	input  logic [ffp_pkg::SPD_W-1:0]         speed,
	input  logic signed [ffp_pkg::ACC_W-1:0]  accel_x,
	input  logic signed [ffp_pkg::ACC_W-1:0]  accel_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ffp_pkg::IDX_W-1:0]         nearest_index,
	output logic [ffp_pkg::ARC_W-1:0]         along_track,
	output logic signed [ffp_pkg::POS_W-1:0]  lateral_offset,
	output logic signed [ffp_pkg::RES_W-1:0]  tangent_speed,
	output logic signed [ffp_pkg::RES_W-1:0]  normal_speed,
	output logic signed [ffp_pkg::RES_W-1:0]  tangent_accel,
	output logic signed [ffp_pkg::RES_W-1:0]  normal_accel
);

	import ffp_pkg::*;

	localparam int AW = $clog2(LANE_DEPTH);

	logic [CNT_W-1:0]      lane_points_q;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	entry_t                wr_data;
	logic [AW-1:0]         rd_addr;
	logic [ENTRY_W-1:0]    rd_raw;
	logic                  q_valid;
	query_t                q_data;
	back_stat_t            back_stat;
	logic [SINE_TABLE_BITS-1:0] rom_addr;
	logic signed [15:0]    rom_data;

	// Point count register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_points_q <= CNT_W'(1);
		end else if (cfg_valid) begin
			lane_points_q <= cfg_data;
		end
	end

	// Item intake and query queue.
	ffp_front #(.LANE_DEPTH(LANE_DEPTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cmd, .point_index, .pos_x, .pos_y,
		.heading, .point_arc, .speed, .accel_x, .accel_y,
		.wr_en, .wr_addr, .wr_data, .q_valid, .q_data, .back_stat
	);

	// Lane point memory.
	ffp_ram #(.WIDTH(ENTRY_W), .DEPTH(LANE_DEPTH)) u_lane_ram (
		.clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
		.raddr(rd_addr), .rdata(rd_raw)
	);

	// Sine table.
	ffp_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
		.clk, .addr(rom_addr), .rdata(rom_data)
	);

	// Scan and projection.
	ffp_back #(.LANE_DEPTH(LANE_DEPTH), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_back (
		.clk, .arst_n, .lane_points(lane_points_q), .q_valid, .q_data, .back_stat,
		.rd_addr, .rd_data(entry_t'(rd_raw)), .rom_addr, .rom_data,
		.out_valid, .out_ready, .nearest_index, .along_track, .lateral_offset,
		.tangent_speed, .normal_speed, .tangent_accel, .normal_accel
	);

endmodule
